// ===== rtl/core/ecm_pkg.sv =====
// Shared types and constants for the elliptic crop and mask block.
package ecm_pkg;

  localparam int PIXEL_BITS      = 8;
  localparam int MAX_DIM_DEFAULT = 4096;
  localparam int DIM_BITS        = 13;
  localparam int POS_BITS        = 12;
  localparam int CFG_IDX_BITS    = 3;
  localparam int CFG_DATA_BITS   = 13;

  localparam logic [DIM_BITS-1:0] RST_FRAME_WIDTH  = 13'd640;
  localparam logic [DIM_BITS-1:0] RST_FRAME_HEIGHT = 13'd480;
  localparam logic [POS_BITS-1:0] RST_CENTRE_X     = 12'd320;
  localparam logic [POS_BITS-1:0] RST_CENTRE_Y     = 12'd240;
  localparam logic [POS_BITS-1:0] RST_RADIUS_X     = 12'd100;
  localparam logic [POS_BITS-1:0] RST_RADIUS_Y     = 12'd100;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_CENTRE_X     = 3'd2,
    CFG_CENTRE_Y     = 3'd3,
    CFG_RADIUS_X     = 3'd4,
    CFG_RADIUS_Y     = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [DIM_BITS-1:0] frame_width;
    logic [DIM_BITS-1:0] frame_height;
    logic [POS_BITS-1:0] centre_x;
    logic [POS_BITS-1:0] centre_y;
    logic [POS_BITS-1:0] radius_x;
    logic [POS_BITS-1:0] radius_y;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LAT_RX,
    S_LAT_RY,
    S_LAT_LIM,
    S_POS,
    S_DIFF,
    S_MUL_XX,
    S_MUL_XR,
    S_MUL_YY,
    S_MUL_YR,
    S_FIN
  } state_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_RX,
    MUL_RY,
    MUL_LIM,
    MUL_AX,
    MUL_TX,
    MUL_AY,
    MUL_TY
  } mul_sel_t;

  typedef struct packed {
    logic     accept;
    logic     latch_win;
    logic     latch_size;
    logic     pos;
    logic     diff;
    logic     out_load;
    mul_sel_t mul_sel;
  } cmd_t;

  typedef struct packed {
    logic in_win;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/core/ecm_if.sv =====
// Valid/ready stream interfaces for the input pixels and the cropped results.
interface pix_in_if import ecm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel;
  logic                  start_of_frame;

  modport source (output valid, output pixel, output start_of_frame, input ready);
  modport sink (input valid, input pixel, input start_of_frame, output ready);
endinterface

interface pix_out_if import ecm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] masked_pixel;
  logic                  inside_ellipse;
  logic [POS_BITS-1:0]   crop_col;
  logic [POS_BITS-1:0]   crop_row;
  logic                  last_of_crop;

  modport source (output valid, output masked_pixel, output inside_ellipse,
                  output crop_col, output crop_row, output last_of_crop, input ready);
  modport sink (input valid, input masked_pixel, input inside_ellipse,
                input crop_col, input crop_row, input last_of_crop, output ready);
endinterface

// ===== rtl/core/ecm_cfg.sv =====
// Configuration register file with its write port.
module ecm_cfg import ecm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width  <= RST_FRAME_WIDTH;
      cfg.frame_height <= RST_FRAME_HEIGHT;
      cfg.centre_x     <= RST_CENTRE_X;
      cfg.centre_y     <= RST_CENTRE_Y;
      cfg.radius_x     <= RST_RADIUS_X;
      cfg.radius_y     <= RST_RADIUS_Y;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  cfg.frame_width  <= cfg_data;
        CFG_FRAME_HEIGHT: cfg.frame_height <= cfg_data;
        CFG_CENTRE_X:     cfg.centre_x     <= cfg_data[POS_BITS-1:0];
        CFG_CENTRE_Y:     cfg.centre_y     <= cfg_data[POS_BITS-1:0];
        CFG_RADIUS_X:     cfg.radius_x     <= cfg_data[POS_BITS-1:0];
        CFG_RADIUS_Y:     cfg.radius_y     <= cfg_data[POS_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/ecm_ctrl.sv =====
// Sequencer: window latch per frame, position, and ellipse test in the window.
module ecm_ctrl import ecm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_sof,
  input  status_t status,
  output logic    in_ready,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.mul_sel = MUL_NONE;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = in_sof ? S_LAT_RX : S_POS;
        end
      end
      S_LAT_RX: begin
        cmd.latch_win = 1'b1;
        cmd.mul_sel   = MUL_RX;
        state_next    = S_LAT_RY;
      end
      S_LAT_RY: begin
        cmd.latch_size = 1'b1;
        cmd.mul_sel    = MUL_RY;
        state_next     = S_LAT_LIM;
      end
      S_LAT_LIM: begin
        cmd.mul_sel = MUL_LIM;
        state_next  = S_POS;
      end
      S_POS: begin
        cmd.pos    = 1'b1;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        // A pixel outside the crop window produces no beat.
        cmd.diff   = 1'b1;
        state_next = status.in_win ? S_MUL_XX : S_IDLE;
      end
      S_MUL_XX: begin
        cmd.mul_sel = MUL_AX;
        state_next  = S_MUL_XR;
      end
      S_MUL_XR: begin
        cmd.mul_sel = MUL_TX;
        state_next  = S_MUL_YY;
      end
      S_MUL_YY: begin
        cmd.mul_sel = MUL_AY;
        state_next  = S_MUL_YR;
      end
      S_MUL_YR: begin
        cmd.mul_sel = MUL_TY;
        state_next  = S_FIN;
      end
      S_FIN: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/ecm_dp.sv =====
// Datapath: frame position, crop window, shared multiplier and output register.
module ecm_dp import ecm_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  cmd_t                  cmd,
  output status_t               status,
  input  logic [PIXEL_BITS-1:0] in_pixel,
  input  logic                  in_sof,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIXEL_BITS-1:0] out_masked_pixel,
  output logic                  out_inside_ellipse,
  output logic [POS_BITS-1:0]   out_crop_col,
  output logic [POS_BITS-1:0]   out_crop_row,
  output logic                  out_last_of_crop
);

  localparam logic [DIM_BITS-1:0] MAX_DIM_V = DIM_BITS'(MAX_DIM);

  // Held input beat.
  logic [PIXEL_BITS-1:0] px;
  logic                  sof;

  // Frame position and latched window.
  logic [POS_BITS-1:0] frame_col, frame_row;
  logic [POS_BITS-1:0] x_start, x_stop, y_start, y_stop;
  logic [DIM_BITS-1:0] num_x, num_y;
  logic                win_ok;

  // Per-pixel working registers.
  logic [POS_BITS-1:0] crop_i, crop_j;
  logic                in_win, last_r;
  logic [12:0]         ax, ay;
  logic [23:0]         rx2, ry2;
  logic [49:0]         limit;
  logic [24:0]         sq;
  logic [48:0]         term_x, term_y;

  // Effective frame size and radii.
  logic [DIM_BITS-1:0] w_eff, h_eff;
  logic [POS_BITS-1:0] rx_eff, ry_eff;

  always_comb begin
    if (cfg.frame_width == '0)          w_eff = DIM_BITS'(1);
    else if (cfg.frame_width > MAX_DIM_V) w_eff = MAX_DIM_V;
    else                                w_eff = cfg.frame_width;
    if (cfg.frame_height == '0)          h_eff = DIM_BITS'(1);
    else if (cfg.frame_height > MAX_DIM_V) h_eff = MAX_DIM_V;
    else                                 h_eff = cfg.frame_height;
    rx_eff = (cfg.radius_x == '0) ? POS_BITS'(1) : cfg.radius_x;
    ry_eff = (cfg.radius_y == '0) ? POS_BITS'(1) : cfg.radius_y;
  end

  // Window bounds: centre minus and plus radius, clamped to the frame.
  logic [POS_BITS-1:0] xs, ys;
  logic [DIM_BITS-1:0] xe_raw, ye_raw, xe, ye;

  always_comb begin
    xs     = (cfg.centre_x > rx_eff) ? cfg.centre_x - rx_eff : '0;
    ys     = (cfg.centre_y > ry_eff) ? cfg.centre_y - ry_eff : '0;
    xe_raw = {1'b0, cfg.centre_x} + {1'b0, rx_eff};
    ye_raw = {1'b0, cfg.centre_y} + {1'b0, ry_eff};
    xe     = (xe_raw > w_eff - DIM_BITS'(1)) ? w_eff - DIM_BITS'(1) : xe_raw;
    ye     = (ye_raw > h_eff - DIM_BITS'(1)) ? h_eff - DIM_BITS'(1) : ye_raw;
  end

  // Position of the current pixel, with wrap at the frame edges.
  logic [POS_BITS-1:0] col0, row0, col_eff, row_eff;
  logic [DIM_BITS-1:0] col_inc, row_inc;

  always_comb begin
    col0    = sof ? '0 : frame_col;
    row0    = sof ? '0 : frame_row;
    col_eff = ({1'b0, col0} >= w_eff) ? '0 : col0;
    row_eff = ({1'b0, row0} >= h_eff) ? '0 : row0;
    col_inc = {1'b0, col_eff} + DIM_BITS'(1);
    row_inc = {1'b0, row_eff} + DIM_BITS'(1);
  end

  // Doubled offsets from the ellipse centre.
  logic signed [13:0] dx, dy;
  logic [13:0]        dx_abs, dy_abs;

  always_comb begin
    dx     = $signed({1'b0, crop_i, 1'b0}) - $signed({1'b0, num_x});
    dy     = $signed({1'b0, crop_j, 1'b0}) - $signed({1'b0, num_y});
    dx_abs = dx[13] ? 14'(-dx) : dx;
    dy_abs = dy[13] ? 14'(-dy) : dy;
  end

  // Shared multiplier.
  logic [24:0] mul_a;
  logic [23:0] mul_b;
  logic [48:0] prod;

  always_comb begin
    case (cmd.mul_sel)
      MUL_RX:  begin mul_a = 25'(rx_eff); mul_b = 24'(rx_eff); end
      MUL_RY:  begin mul_a = 25'(ry_eff); mul_b = 24'(ry_eff); end
      MUL_LIM: begin mul_a = {1'b0, rx2}; mul_b = ry2;         end
      MUL_AX:  begin mul_a = 25'(ax);     mul_b = 24'(ax);     end
      MUL_TX:  begin mul_a = sq;          mul_b = ry2;         end
      MUL_AY:  begin mul_a = 25'(ay);     mul_b = 24'(ay);     end
      MUL_TY:  begin mul_a = sq;          mul_b = rx2;         end
      default: begin mul_a = '0;          mul_b = '0;          end
    endcase
  end

  assign prod = mul_a * mul_b;

  logic [49:0] lhs;
  logic        in_ellipse;

  assign lhs        = {1'b0, term_x} + {1'b0, term_y};
  assign in_ellipse = lhs <= limit;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_col <= '0;
      frame_row <= '0;
      win_ok    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.latch_win) begin
        win_ok <= ({1'b0, xs} <= xe) && ({1'b0, ys} <= ye);
      end
      if (cmd.pos) begin
        if (col_inc >= w_eff) begin
          frame_col <= '0;
          frame_row <= (row_inc >= h_eff) ? '0 : row_inc[POS_BITS-1:0];
        end else begin
          frame_col <= col_inc[POS_BITS-1:0];
          frame_row <= row_eff;
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      px  <= in_pixel;
      sof <= in_sof;
    end
    if (cmd.latch_win) begin
      x_start <= xs;
      x_stop  <= xe[POS_BITS-1:0];
      y_start <= ys;
      y_stop  <= ye[POS_BITS-1:0];
    end
    if (cmd.latch_size) begin
      num_x <= {1'b0, x_stop} - {1'b0, x_start} + DIM_BITS'(1);
      num_y <= {1'b0, y_stop} - {1'b0, y_start} + DIM_BITS'(1);
    end
    if (cmd.pos) begin
      in_win <= win_ok && (col_eff >= x_start) && (col_eff <= x_stop) &&
                (row_eff >= y_start) && (row_eff <= y_stop);
      crop_i <= col_eff - x_start;
      crop_j <= row_eff - y_start;
      last_r <= (col_eff == x_stop) && (row_eff == y_stop);
    end
    if (cmd.diff) begin
      ax <= dx_abs[12:0];
      ay <= dy_abs[12:0];
    end
    case (cmd.mul_sel)
      MUL_RX:  rx2    <= prod[23:0];
      MUL_RY:  ry2    <= prod[23:0];
      MUL_LIM: limit  <= {prod[47:0], 2'b00};
      MUL_AX:  sq     <= prod[24:0];
      MUL_TX:  term_x <= prod;
      MUL_AY:  sq     <= prod[24:0];
      MUL_TY:  term_y <= prod;
      default: ;
    endcase
    if (cmd.out_load) begin
      out_masked_pixel   <= in_ellipse ? px : '0;
      out_inside_ellipse <= in_ellipse;
      out_crop_col       <= crop_i;
      out_crop_row       <= crop_j;
      out_last_of_crop   <= last_r;
    end
  end

  assign status.in_win   = in_win;
  assign status.out_free = !out_valid || out_ready;

endmodule

// ===== rtl/core/elliptic_roi_crop_mask.sv =====
// Top level: crops a raster pixel stream to a window and masks it to an ellipse.
// An input beat is taken only when the sequencer is idle; a pixel outside the crop
// window passes S_POS and S_DIFF, one inside it also S_MUL_XX to S_MUL_YR and S_FIN
// (one shared 25x24 multiplier used four times); a start-of-frame pixel first passes
// S_LAT_RX to S_LAT_LIM to latch the window. S_FIN waits for out_free to load the result.
// Synchronous reset clears position, window-valid, sequencer state and output valid.
module elliptic_roi_crop_mask import ecm_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  pix_in_if.sink                   pix_in,
  pix_out_if.source                pix_out
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  ecm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ecm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pix_in.valid),
    .in_sof   (pix_in.start_of_frame),
    .status   (status),
    .in_ready (pix_in.ready),
    .cmd      (cmd)
  );

  ecm_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cfg                (cfg),
    .cmd                (cmd),
    .status             (status),
    .in_pixel           (pix_in.pixel),
    .in_sof             (pix_in.start_of_frame),
    .out_valid          (pix_out.valid),
    .out_ready          (pix_out.ready),
    .out_masked_pixel   (pix_out.masked_pixel),
    .out_inside_ellipse (pix_out.inside_ellipse),
    .out_crop_col       (pix_out.crop_col),
    .out_crop_row       (pix_out.crop_row),
    .out_last_of_crop   (pix_out.last_of_crop)
  );

  // Work on one pixel at a time: an accepted beat is never followed by another at once.
  assert property (@(posedge clk) disable iff (rst) cmd.accept |=> !cmd.accept)
    else $error("two input beats accepted back to back");

  // A frame start always latches the window before the position step.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && pix_in.start_of_frame) |=> cmd.latch_win)
    else $error("frame start did not latch the window");

  // The output register is loaded only when it is free and only for window pixels.
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (status.out_free && status.in_win))
    else $error("result loaded into a busy register or for a pixel outside the window");

  // No new input beat is offered while a result is being loaded.
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !pix_in.ready)
    else $error("input ready while a result is being loaded");

endmodule

// ===== sim/elliptic_roi_crop_mask_tb.sv =====
// Self-checking testbench for the elliptic crop and mask block, with a predictor and scoreboard.
module elliptic_roi_crop_mask_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ecm_pkg::*;

  localparam int CLK_PERIOD    = 20;
  localparam int RESET_CYCLES  = 10;
  localparam int IDLE_PCT      = 9;
  localparam int SETTLE_CYCLES = 32;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_ITEMS  = 400;
  localparam int LARGE_ITEMS   = 300;
  localparam int FRAME_CAP     = 200;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int MAX_PRINTS    = 100;
  localparam int FRAME_MAX     = MAX_DIM_DEFAULT;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] masked_pixel;
    logic                  inside_ellipse;
    logic [POS_BITS-1:0]   crop_col;
    logic [POS_BITS-1:0]   crop_row;
    logic                  last_of_crop;
  } crop_beat_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     cfg_write;
  cfg_index_t               cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  pix_in_if  pix_in ();
  pix_out_if pix_out ();

  elliptic_roi_crop_mask u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_in    (pix_in),
    .pix_out   (pix_out)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Register shadow and the crop state latched at each start of frame.
  cfg_t                shadow_cfg;
  logic [POS_BITS-1:0] pos_col;
  logic [POS_BITS-1:0] pos_row;
  logic [POS_BITS-1:0] roi_x_lo;
  logic [POS_BITS-1:0] roi_x_hi;
  logic [POS_BITS-1:0] roi_y_lo;
  logic [POS_BITS-1:0] roi_y_hi;
  logic [POS_BITS-1:0] roi_rx;
  logic [POS_BITS-1:0] roi_ry;
  logic [49:0]         ellipse_bound;
  logic                roi_valid;

  crop_beat_t  expected_beats[$];
  int unsigned error_count = 0;
  int unsigned items_sent  = 0;
  logic        idle_enable;
  logic        sink_hold;

  function automatic int effective_dim(input logic [DIM_BITS-1:0] v);
    if (v == 0) return 1;
    if (v > FRAME_MAX) return FRAME_MAX;
    return int'(v);
  endfunction

  function automatic void latch_roi();
    int w, h, cx, cy, rx, ry, xs, xe, ys, ye;
    w  = effective_dim(shadow_cfg.frame_width);
    h  = effective_dim(shadow_cfg.frame_height);
    cx = int'(shadow_cfg.centre_x);
    cy = int'(shadow_cfg.centre_y);
    rx = (shadow_cfg.radius_x == 0) ? 1 : int'(shadow_cfg.radius_x);
    ry = (shadow_cfg.radius_y == 0) ? 1 : int'(shadow_cfg.radius_y);
    xs = (cx > rx) ? cx - rx : 0;
    ys = (cy > ry) ? cy - ry : 0;
    xe = cx + rx;
    ye = cy + ry;
    if (xe > w - 1) xe = w - 1;
    if (ye > h - 1) ye = h - 1;
    roi_x_lo      = POS_BITS'(xs);
    roi_x_hi      = POS_BITS'(xe);
    roi_y_lo      = POS_BITS'(ys);
    roi_y_hi      = POS_BITS'(ye);
    roi_valid     = (xs <= xe) && (ys <= ye);
    roi_rx        = POS_BITS'(rx);
    roi_ry        = POS_BITS'(ry);
    ellipse_bound = 50'(64'd4 * rx * rx * ry * ry);
  endfunction

  // Advances the frame position by one pixel and queues the beat it causes, if any.
  function automatic void predict_pixel(input logic [PIXEL_BITS-1:0] px, input logic sof);
    int              w, h, ci, cj, nx, ny, dx, dy;
    longint unsigned ax, ay, lhs;
    logic            in_ellipse;
    crop_beat_t      beat;
    w = effective_dim(shadow_cfg.frame_width);
    h = effective_dim(shadow_cfg.frame_height);
    if (sof) begin
      pos_col = '0;
      pos_row = '0;
      latch_roi();
    end
    if (pos_col >= w) pos_col = '0;
    if (pos_row >= h) pos_row = '0;
    if (roi_valid && pos_col >= roi_x_lo && pos_col <= roi_x_hi &&
        pos_row >= roi_y_lo && pos_row <= roi_y_hi) begin
      ci  = int'(pos_col) - int'(roi_x_lo);
      cj  = int'(pos_row) - int'(roi_y_lo);
      nx  = int'(roi_x_hi) - int'(roi_x_lo) + 1;
      ny  = int'(roi_y_hi) - int'(roi_y_lo) + 1;
      dx  = 2 * ci - nx;
      dy  = 2 * cj - ny;
      ax  = (dx < 0) ? -dx : dx;
      ay  = (dy < 0) ? -dy : dy;
      lhs = ax * ax * roi_ry * roi_ry + ay * ay * roi_rx * roi_rx;
      in_ellipse = (lhs <= 64'(ellipse_bound));
      beat.masked_pixel   = in_ellipse ? px : '0;
      beat.inside_ellipse = in_ellipse;
      beat.crop_col       = POS_BITS'(ci);
      beat.crop_row       = POS_BITS'(cj);
      beat.last_of_crop   = (pos_col == roi_x_hi) && (pos_row == roi_y_hi);
      expected_beats.insert(expected_beats.size(), beat);
    end
    if (int'(pos_col) + 1 >= w) begin
      pos_col = '0;
      pos_row = (int'(pos_row) + 1 >= h) ? '0 : pos_row + 1'b1;
    end else begin
      pos_col = pos_col + 1'b1;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (error_count < MAX_PRINTS)
      $display("mismatch %s: got %0h, expected %0h", what, got, want);
    error_count++;
  endtask

  task automatic check_beat();
    crop_beat_t want;
    if (expected_beats.size() == 0) begin
      report_mismatch("beat with nothing expected", pix_out.crop_col, 0);
      return;
    end
    want = expected_beats.pop_front();
    if (pix_out.masked_pixel !== want.masked_pixel)
      report_mismatch("masked_pixel", pix_out.masked_pixel, want.masked_pixel);
    if (pix_out.inside_ellipse !== want.inside_ellipse)
      report_mismatch("inside_ellipse", pix_out.inside_ellipse, want.inside_ellipse);
    if (pix_out.crop_col !== want.crop_col)
      report_mismatch("crop_col", pix_out.crop_col, want.crop_col);
    if (pix_out.crop_row !== want.crop_row)
      report_mismatch("crop_row", pix_out.crop_row, want.crop_row);
    if (pix_out.last_of_crop !== want.last_of_crop)
      report_mismatch("last_of_crop", pix_out.last_of_crop, want.last_of_crop);
  endtask

  // Output side: check each accepted beat, then pick the next ready.
  always @(posedge clk) begin
    if (!rst && pix_out.valid === 1'b1 && pix_out.ready) check_beat();
    if (sink_hold) begin
      pix_out.ready <= 1'b0;
    end else if (idle_enable) begin
      pix_out.ready <= ($urandom_range(99) >= IDLE_PCT);
    end else begin
      pix_out.ready <= 1'b1;
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  task automatic send_pixel(input logic [PIXEL_BITS-1:0] px, input logic sof);
    while (idle_enable && $urandom_range(99) < IDLE_PCT) begin
      pix_in.valid <= 1'b0;
      @(posedge clk);
    end
    pix_in.valid          <= 1'b1;
    pix_in.pixel          <= px;
    pix_in.start_of_frame <= sof;
    @(posedge clk);
    while (!pix_in.ready) @(posedge clk);
    predict_pixel(px, sof);
    items_sent++;
  endtask

  // Stops the input and waits until the block has nothing left in flight.
  task automatic drain();
    pix_in.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input int unsigned value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_BITS'(value);
    @(posedge clk);
    case (idx)
      CFG_FRAME_WIDTH:  shadow_cfg.frame_width  = DIM_BITS'(value);
      CFG_FRAME_HEIGHT: shadow_cfg.frame_height = DIM_BITS'(value);
      CFG_CENTRE_X:     shadow_cfg.centre_x     = POS_BITS'(value);
      CFG_CENTRE_Y:     shadow_cfg.centre_y     = POS_BITS'(value);
      CFG_RADIUS_X:     shadow_cfg.radius_x     = POS_BITS'(value);
      CFG_RADIUS_Y:     shadow_cfg.radius_y     = POS_BITS'(value);
      default: ;
    endcase
  endtask

  task automatic set_regs(input int unsigned fw, fh, cx, cy, rx, ry);
    drain();
    write_reg(CFG_FRAME_WIDTH, fw);
    write_reg(CFG_FRAME_HEIGHT, fh);
    write_reg(CFG_CENTRE_X, cx);
    write_reg(CFG_CENTRE_Y, cy);
    write_reg(CFG_RADIUS_X, rx);
    write_reg(CFG_RADIUS_Y, ry);
    cfg_write <= 1'b0;
  endtask

  // No window has been latched yet, so nothing may come out.
  task automatic test_before_first_frame();
    send_pixel(8'h00, 1'b0);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h5A, 1'b0);
    // Reset registers give a window far from the frame origin.
    send_pixel(8'hFF, 1'b1);
    send_pixel(8'h00, 1'b0);
    drain();
  endtask

  task automatic test_small_ellipse();
    set_regs(5, 4, 2, 1, 1, 1);
    for (int k = 0; k < 20; k++) send_pixel(k[0] ? 8'hFF : 8'h00, k == 0);
    drain();
  endtask

  task automatic test_empty_window();
    // Start beyond the clamped stop on the x axis, then on the y axis.
    set_regs(5, 3, 10, 1, 1, 1);
    for (int k = 0; k < 15; k++) send_pixel(8'hFF, k == 0);
    set_regs(4, 2, 1, 9, 1, 1);
    for (int k = 0; k < 8; k++) send_pixel(8'hA5, k == 0);
    drain();
  endtask

  task automatic test_zero_radius();
    set_regs(4, 4, 1, 1, 0, 0);
    for (int k = 0; k < 16; k++) send_pixel(8'(8'hF0 ^ k), k == 0);
    drain();
  endtask

  task automatic test_size_clamp();
    // Width 0 acts as one column, height 8191 as the largest frame.
    set_regs(0, 8191, 0, 4095, 2, 4095);
    for (int k = 0; k < 12; k++) send_pixel(8'(k * 23), k == 0);
    set_regs(8191, 0, 4095, 0, 3, 2);
    for (int k = 0; k < 6; k++) send_pixel(8'hFF, k == 0);
    drain();
  endtask

  task automatic test_wrap_and_shrink();
    set_regs(3, 2, 1, 0, 1, 1);
    // The frame repeats without a start mark and reuses the latched window.
    for (int k = 0; k < 14; k++) send_pixel(8'(k + 1), k == 0);
    // Shrinking the width puts the current column beyond the new edge.
    set_regs(2, 2, 0, 0, 4, 4);
    for (int k = 0; k < 5; k++) send_pixel(8'(8'h80 + k), 1'b0);
    drain();
  endtask

  // The start of a row at the largest frame size and large radii, where the ellipse edge
  // is crossed, without any idling on either side.
  task automatic test_full_row();
    set_regs(4096, 4096, 2047, 4095, 2048, 4095);
    idle_enable <= 1'b0;
    for (int k = 0; k < LARGE_ITEMS; k++) send_pixel(8'($urandom_range(255)), k == 0);
    drain();
    idle_enable <= 1'b1;
    @(posedge clk);
  endtask

  task automatic test_output_stall();
    set_regs(6, 5, 3, 2, 4, 3);
    fork
      begin
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold <= 1'b0;
      end
    join_none
    for (int k = 0; k < 30; k++) send_pixel(8'($urandom_range(255)), k == 0);
    drain();
  endtask

  task automatic test_random_frames();
    int unsigned fw, fh, cx, cy, rx, ry, npix, first_item;
    int          w, h, frames;
    logic        sof;
    first_item = items_sent;
    while (items_sent - first_item < RANDOM_ITEMS) begin
      fw = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      fh = ($urandom_range(9) == 0) ? $urandom_range(11, 30) : $urandom_range(1, 10);
      if ($urandom_range(29) == 0) fw = $urandom_range(1) ? 0 : $urandom_range(4097, 8191);
      if ($urandom_range(29) == 0) fh = $urandom_range(1) ? 0 : $urandom_range(4097, 8191);
      w  = effective_dim(DIM_BITS'(fw));
      h  = effective_dim(DIM_BITS'(fh));
      cx = ($urandom_range(19) == 0) ? $urandom_range(4095) : $urandom_range(0, w + 2) % 4096;
      cy = ($urandom_range(19) == 0) ? $urandom_range(4095) : $urandom_range(0, h + 2) % 4096;
      rx = ($urandom_range(14) == 0) ? $urandom_range(4095) : $urandom_range(0, 6);
      ry = ($urandom_range(14) == 0) ? $urandom_range(4095) : $urandom_range(0, 6);
      set_regs(fw, fh, cx, cy, rx, ry);
      frames = $urandom_range(1, 3);
      repeat (frames) begin
        npix = w * h;
        // Some frames come short or long, which shifts the next one.
        if ($urandom_range(7) == 0) begin
          npix = $urandom_range(1) ? npix + $urandom_range(1, 4) :
                 (npix > 2 ? npix - $urandom_range(1, 2) : npix);
        end
        if (npix > FRAME_CAP) npix = FRAME_CAP;
        for (int k = 0; k < npix; k++) begin
          sof = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(199) == 0);
          send_pixel(8'($urandom_range(255)), sof);
        end
      end
    end
    drain();
  endtask

  initial begin
    rst                   = 1'b1;
    cfg_write             = 1'b0;
    cfg_index             = CFG_FRAME_WIDTH;
    cfg_data              = '0;
    pix_in.valid          = 1'b0;
    pix_in.pixel          = '0;
    pix_in.start_of_frame = 1'b0;
    pix_out.ready         = 1'b0;
    idle_enable           = 1'b1;
    sink_hold             = 1'b0;
    shadow_cfg.frame_width  = RST_FRAME_WIDTH;
    shadow_cfg.frame_height = RST_FRAME_HEIGHT;
    shadow_cfg.centre_x     = RST_CENTRE_X;
    shadow_cfg.centre_y     = RST_CENTRE_Y;
    shadow_cfg.radius_x     = RST_RADIUS_X;
    shadow_cfg.radius_y     = RST_RADIUS_Y;
    pos_col       = '0;
    pos_row       = '0;
    roi_x_lo      = '0;
    roi_x_hi      = '0;
    roi_y_lo      = '0;
    roi_y_hi      = '0;
    roi_rx        = '0;
    roi_ry        = '0;
    ellipse_bound = '0;
    roi_valid     = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_before_first_frame();
    test_small_ellipse();
    test_empty_window();
    test_zero_radius();
    test_size_clamp();
    test_wrap_and_shrink();
    test_full_row();
    test_output_stall();
    test_random_frames();

    if (expected_beats.size() != 0)
      report_mismatch("beats never delivered", expected_beats.size(), 0);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/ecm_pkg.sv
rtl/core/ecm_if.sv
rtl/core/ecm_cfg.sv
rtl/core/ecm_ctrl.sv
rtl/core/ecm_dp.sv
rtl/core/elliptic_roi_crop_mask.sv
sim/elliptic_roi_crop_mask_tb.sv
